// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/sdat_pkg.sv =====
// ----------------------------------------------------------------------------
// sdat_pkg
// Constants and codes of the shower direction pipeline.
// ----------------------------------------------------------------------------
package sdat_pkg;
	localparam int TIME_BITS  = 16;
	localparam int POS_BITS   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// one tick of light travel in mm, scaled by 2^24
	localparam logic [26:0] KSCALED = 27'd125742071;

	localparam int DEN_W      = 32;
	localparam int NUM_W      = 50;
	localparam int DIV_STEPS  = 17;
	localparam int SQRT_STEPS = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DET2_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DET2_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DET3_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DET3_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF1   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFF2   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFF3   = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OOV   = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;
endpackage

// ===== hw/rtl/shower_direction_from_arrival_times_top.sv =====
// ----------------------------------------------------------------------------
// shower_direction_from_arrival_times_top
// Plane-wave shower direction from three detector arrival times.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | time_det1, time_det2, time_det3
//  out      | out_valid / out_ready  | dir_x, dir_y, dir_z, status
//  cfg      | cfg_we                 | cfg_addr, cfg_wdata
//
//  one request per cycle while the skid is empty; pipeline of 7 front stages,
//  17 quotient-bit stages, 2 square stages, 16 root-bit stages, 1 output
//  stage and 1 output register.
//  arst_n clears all valid bits and the config registers to zero.
//  a stalled output keeps the pipeline moving into a one-entry skid; input
//  stalls only while the skid is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shower_direction_from_arrival_times_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sdat_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [sdat_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [sdat_pkg::TIME_BITS-1:0] time_det1,
	input  logic signed [sdat_pkg::TIME_BITS-1:0] time_det2,
	input  logic signed [sdat_pkg::TIME_BITS-1:0] time_det3,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [15:0]                    dir_x,
	output logic signed [15:0]                    dir_y,
	output logic [14:0]                           dir_z,
	output logic [1:0]                            status
);
	import sdat_pkg::*;

	typedef struct packed {
		logic [DEN_W-1:0]     rem_x;
		logic [DEN_W-1:0]     rem_y;
		logic [DIV_STEPS-1:0] low_x;
		logic [DIV_STEPS-1:0] low_y;
		logic [DIV_STEPS-1:0] q_x;
		logic [DIV_STEPS-1:0] q_y;
		logic [DEN_W-1:0]     dabs;
		logic                 ovf_x;
		logic                 ovf_y;
		logic                 sgn_x;
		logic                 sgn_y;
		logic                 degen;
	} dv_t;

	typedef struct packed {
		logic [30:0]        rem;
		logic [15:0]        root;
		logic signed [15:0] xv;
		logic signed [15:0] yv;
		logic [1:0]         st;
	} sq_t;

	typedef struct packed {
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [14:0]        dz;
		logic [1:0]         st;
	} res_t;

	// one restoring quotient bit for both components
	function automatic dv_t div_step(input dv_t d);
		dv_t        n;
		logic [DEN_W:0] r2x;
		logic [DEN_W:0] r2y;
		logic [DEN_W:0] den;
		logic           gx;
		logic           gy;
		n   = d;
		den = {1'b0, d.dabs};
		r2x = {d.rem_x, d.low_x[DIV_STEPS-1]};
		r2y = {d.rem_y, d.low_y[DIV_STEPS-1]};
		gx  = r2x >= den;
		gy  = r2y >= den;
		n.rem_x = gx ? DEN_W'(r2x - den) : r2x[DEN_W-1:0];
		n.rem_y = gy ? DEN_W'(r2y - den) : r2y[DEN_W-1:0];
		n.low_x = {d.low_x[DIV_STEPS-2:0], 1'b0};
		n.low_y = {d.low_y[DIV_STEPS-2:0], 1'b0};
		n.q_x   = {d.q_x[DIV_STEPS-2:0], gx};
		n.q_y   = {d.q_y[DIV_STEPS-2:0], gy};
		return n;
	endfunction

	// one root bit at position b, remainder kept as v - root^2
	function automatic sq_t sqrt_step(input sq_t s, input int b);
		sq_t         n;
		logic [32:0] trial;
		n     = s;
		trial = (33'(s.root) << (b + 1)) + (33'd1 << (2 * b));
		if ({2'b00, s.rem} >= trial) begin
			n.rem  = 31'({2'b00, s.rem} - trial);
			n.root = s.root | (16'd1 << b);
		end
		return n;
	endfunction

	// configuration registers
	logic signed [POS_BITS-1:0]  x1_q, y1_q, x2_q, y2_q;
	logic signed [TIME_BITS-1:0] off1_q, off2_q, off3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q   <= '0;
			y1_q   <= '0;
			x2_q   <= '0;
			y2_q   <= '0;
			off1_q <= '0;
			off2_q <= '0;
			off3_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DET2_X: x1_q   <= cfg_wdata;
				REG_DET2_Y: y1_q   <= cfg_wdata;
				REG_DET3_X: x2_q   <= cfg_wdata;
				REG_DET3_Y: y2_q   <= cfg_wdata;
				REG_OFF1:   off1_q <= cfg_wdata;
				REG_OFF2:   off2_q <= cfg_wdata;
				REG_OFF3:   off3_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic en;
	logic skid_vld_q;
	logic out_vld_q;
	logic take;

	assign en       = !skid_vld_q;
	assign in_ready = en;
	assign take     = out_vld_q && out_ready;

	// front stage comb
	logic signed [TIME_BITS-1:0] c1, c2, c3;
	assign c1 = time_det1 + off1_q;
	assign c2 = time_det2 + off2_q;
	assign c3 = time_det3 + off3_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [DIV_STEPS-1:0]  v_sd;
	logic [SQRT_STEPS-1:0] v_sr;

	logic signed [TIME_BITS-1:0] t1_s1, t2_s1;
	logic signed [31:0] pd1_s2, pd2_s2, px1_s2, px2_s2, py1_s2, py2_s2;
	logic signed [32:0] d_s3, nx_s3, ny_s3;
	logic [DEN_W-1:0]   dabs_s4, nxa_s4, nya_s4;
	logic               sx_s4, sy_s4, dg_s4;
	logic [58:0]        ax_s5, ay_s5;
	logic [DEN_W-1:0]   dabs_s5;
	logic               sx_s5, sy_s5, dg_s5;
	logic [NUM_W-1:0]   numx_s6, numy_s6;
	logic [DEN_W-1:0]   dabs_s6;
	logic               sx_s6, sy_s6, dg_s6;
	dv_t                dv_s7;
	dv_t                dv_sd [DIV_STEPS];
	dv_t                dv_nx [DIV_STEPS];
	logic signed [15:0] xv_s8, yv_s8;
	logic [33:0]        sqx_s8, sqy_s8;
	logic [1:0]         st_s8;
	sq_t                sq_s9;
	sq_t                sq_sr [SQRT_STEPS];
	sq_t                sq_nx [SQRT_STEPS];
	res_t               res_s10;
	res_t               out_q, skid_q;

	logic signed [32:0] d_n, nx_n, ny_n;
	logic [59:0]        sumx_n, sumy_n;
	logic [NUM_W:17]    hix, hiy;
	logic [DIV_STEPS-1:0] qx_f, qy_f;
	logic               oov_n;
	logic signed [34:0] zsq_n;
	logic [15:0]        root_f;

	assign d_n  = 33'(pd1_s2) - 33'(pd2_s2);
	assign nx_n = 33'(py1_s2) - 33'(py2_s2);
	assign ny_n = 33'(px1_s2) - 33'(px2_s2);

	// rounding: floor((a + |D|*256) / 2^9) / |D|
	assign sumx_n = {1'b0, ax_s5} + (60'(dabs_s5) << 8);
	assign sumy_n = {1'b0, ay_s5} + (60'(dabs_s5) << 8);
	assign hix    = {1'b0, numx_s6[NUM_W-1:17]};
	assign hiy    = {1'b0, numy_s6[NUM_W-1:17]};

	always_comb begin
		dv_nx[0] = div_step(dv_s7);
		for (int j = 1; j < DIV_STEPS; j++) begin
			dv_nx[j] = div_step(dv_sd[j-1]);
		end
	end

	assign qx_f  = dv_sd[DIV_STEPS-1].q_x;
	assign qy_f  = dv_sd[DIV_STEPS-1].q_y;
	assign oov_n = dv_sd[DIV_STEPS-1].ovf_x || dv_sd[DIV_STEPS-1].ovf_y
		|| (qx_f > 17'd32768) || (qy_f > 17'd32768);
	assign zsq_n = (35'sd1 <<< 30) - 35'($signed({1'b0, sqx_s8}))
		- 35'($signed({1'b0, sqy_s8}));

	genvar gi;
	generate
		for (gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
			if (gi == 0) begin : g_first
				assign sq_nx[gi] = sqrt_step(sq_s9, SQRT_STEPS - 1 - gi);
			end else begin : g_rest
				assign sq_nx[gi] = sqrt_step(sq_sr[gi-1], SQRT_STEPS - 1 - gi);
			end
		end
	endgenerate

	assign root_f = sq_sr[SQRT_STEPS-1].root;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_sd  <= '0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_sr  <= '0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_sd  <= {v_sd[DIV_STEPS-2:0], v_s7};
			v_s8  <= v_sd[DIV_STEPS-1];
			v_s9  <= v_s8;
			v_sr  <= {v_sr[SQRT_STEPS-2:0], v_s9};
			v_s10 <= v_sr[SQRT_STEPS-1];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1 <= c2 - c1;
			t2_s1 <= c3 - c1;

			pd1_s2 <= x1_q * y2_q;
			pd2_s2 <= x2_q * y1_q;
			py1_s2 <= t2_s1 * y1_q;
			py2_s2 <= t1_s1 * y2_q;
			px1_s2 <= t1_s1 * x2_q;
			px2_s2 <= t2_s1 * x1_q;

			d_s3  <= d_n;
			nx_s3 <= nx_n;
			ny_s3 <= ny_n;

			dabs_s4 <= d_s3[32] ? DEN_W'(-d_s3) : d_s3[DEN_W-1:0];
			nxa_s4  <= nx_s3[32] ? DEN_W'(-nx_s3) : nx_s3[DEN_W-1:0];
			nya_s4  <= ny_s3[32] ? DEN_W'(-ny_s3) : ny_s3[DEN_W-1:0];
			sx_s4   <= nx_s3[32] ^ d_s3[32];
			sy_s4   <= ny_s3[32] ^ d_s3[32];
			dg_s4   <= d_s3 == '0;

			ax_s5   <= nxa_s4 * KSCALED;
			ay_s5   <= nya_s4 * KSCALED;
			dabs_s5 <= dabs_s4;
			sx_s5   <= sx_s4;
			sy_s5   <= sy_s4;
			dg_s5   <= dg_s4;

			numx_s6 <= sumx_n[58:9];
			numy_s6 <= sumy_n[58:9];
			dabs_s6 <= dabs_s5;
			sx_s6   <= sx_s5;
			sy_s6   <= sy_s5;
			dg_s6   <= dg_s5;

			// quotient of 2^17 or more is out of range
			dv_s7.ovf_x <= hix >= {1'b0, dabs_s6};
			dv_s7.ovf_y <= hiy >= {1'b0, dabs_s6};
			dv_s7.rem_x <= numx_s6[48:17];
			dv_s7.rem_y <= numy_s6[48:17];
			dv_s7.low_x <= numx_s6[16:0];
			dv_s7.low_y <= numy_s6[16:0];
			dv_s7.q_x   <= '0;
			dv_s7.q_y   <= '0;
			dv_s7.dabs  <= dabs_s6;
			dv_s7.sgn_x <= sx_s6;
			dv_s7.sgn_y <= sy_s6;
			dv_s7.degen <= dg_s6;

			for (int j = 0; j < DIV_STEPS; j++) begin
				dv_sd[j] <= dv_nx[j];
			end

			if (dv_sd[DIV_STEPS-1].degen) begin
				st_s8 <= ST_DEGEN;
			end else if (oov_n) begin
				st_s8 <= ST_OOV;
			end else begin
				st_s8 <= ST_OK;
			end
			xv_s8  <= dv_sd[DIV_STEPS-1].sgn_x ? 16'(-qx_f)
				: (qx_f[15] ? 16'sd32767 : 16'(qx_f));
			yv_s8  <= dv_sd[DIV_STEPS-1].sgn_y ? 16'(-qy_f)
				: (qy_f[15] ? 16'sd32767 : 16'(qy_f));
			sqx_s8 <= qx_f * qx_f;
			sqy_s8 <= qy_f * qy_f;

			sq_s9.rem  <= zsq_n[30:0];
			sq_s9.root <= '0;
			sq_s9.xv   <= xv_s8;
			sq_s9.yv   <= yv_s8;
			sq_s9.st   <= (st_s8 == ST_OK && zsq_n[34]) ? ST_OOV : st_s8;

			for (int j = 0; j < SQRT_STEPS; j++) begin
				sq_sr[j] <= sq_nx[j];
			end

			if (sq_sr[SQRT_STEPS-1].st == ST_OK) begin
				res_s10.dx <= sq_sr[SQRT_STEPS-1].xv;
				res_s10.dy <= sq_sr[SQRT_STEPS-1].yv;
				res_s10.dz <= root_f[15] ? 15'h7fff : root_f[14:0];
			end else begin
				res_s10.dx <= '0;
				res_s10.dy <= '0;
				res_s10.dz <= '0;
			end
			res_s10.st <= sq_sr[SQRT_STEPS-1].st;
		end
	end

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (v_s10) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (v_s10) begin
			if (!out_vld_q || take) begin
				out_q <= res_s10;
			end else begin
				skid_q <= res_s10;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign dir_x     = out_q.dx;
	assign dir_y     = out_q.dy;
	assign dir_z     = out_q.dz;
	assign status    = out_q.st;

	`ASSERT_NEVER(a_skid_without_out, clk, arst_n, skid_vld_q && !out_vld_q,
		"skid holds a result while the output register is empty")
	`ASSERT_CLK(a_skid_fill, clk, arst_n,
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready),
		"skid filled while the output was free")
	`ASSERT_NEVER(a_bad_zero, clk, arst_n,
		out_vld_q && out_q.st != ST_OK
		&& (out_q.dx != 16'sd0 || out_q.dy != 16'sd0 || out_q.dz != 15'd0),
		"non-valid status with nonzero direction")
endmodule

// ===== sim/shower_direction_from_arrival_times_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shower_direction_from_arrival_times_top_tb
// Drives arrival-time requests through the direction pipeline under random
// stalls on both channels. A local plane-wave solver predicts each direction
// and status, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module shower_direction_from_arrival_times_top_tb;
	import sdat_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        z;
		logic [1:0]         st;
	} direction_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_addr = '0;
	logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [TIME_BITS-1:0] time_det1 = '0;
	logic signed [TIME_BITS-1:0] time_det2 = '0;
	logic signed [TIME_BITS-1:0] time_det3 = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [15:0]          dir_x;
	logic signed [15:0]          dir_y;
	logic [14:0]                 dir_z;
	logic [1:0]                  status;

	// local copy of the geometry and offsets
	logic signed [15:0] geo[7];
	direction_t         pending_dirs[$];
	int                 mismatches = 0;
	int                 stall_cycles = 0;
	bit                 no_idle = 1'b0;

	shower_direction_from_arrival_times_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.time_det1 (time_det1),
		.time_det2 (time_det2),
		.time_det3 (time_det3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.status    (status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint round_div(longint n, longint d);
		bit      neg;
		longint  a;
		longint  b;
		neg = (n < 0) != (d < 0);
		a = (n < 0) ? -n : n;
		b = (d < 0) ? -d : d;
		return neg ? -((2 * a + b) / (2 * b)) : (2 * a + b) / (2 * b);
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint r;
		longint b;
		r = 0;
		b = 64'd1 << 30;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic direction_t solve_direction(logic signed [15:0] a1,
			logic signed [15:0] a2, logic signed [15:0] a3);
		direction_t         r;
		logic signed [15:0] c1;
		logic signed [15:0] c2;
		logic signed [15:0] c3;
		logic signed [15:0] dt1;
		logic signed [15:0] dt2;
		longint             det;
		longint             xq;
		longint             yq;
		longint             zsq;
		longint             zr;
		c1 = a1 + geo[REG_OFF1];
		c2 = a2 + geo[REG_OFF2];
		c3 = a3 + geo[REG_OFF3];
		dt1 = c2 - c1;
		dt2 = c3 - c1;
		r = '0;
		det = longint'(geo[REG_DET2_X]) * geo[REG_DET3_Y]
			- longint'(geo[REG_DET3_X]) * geo[REG_DET2_Y];
		if (det == 0) begin
			r.st = ST_DEGEN;
			return r;
		end
		xq = round_div((longint'(dt2) * geo[REG_DET2_Y] - longint'(dt1) * geo[REG_DET3_Y])
			* longint'(KSCALED), det * 512);
		yq = round_div((longint'(dt1) * geo[REG_DET3_X] - longint'(dt2) * geo[REG_DET2_X])
			* longint'(KSCALED), det * 512);
		r.st = ST_OOV;
		if (xq > 32768 || xq < -32768 || yq > 32768 || yq < -32768)
			return r;
		zsq = (64'd1 << 30) - xq * xq - yq * yq;
		if (zsq < 0)
			return r;
		zr = floor_sqrt(zsq);
		r.x = (xq > 32767) ? 16'sd32767 : xq[15:0];
		r.y = (yq > 32767) ? 16'sd32767 : yq[15:0];
		r.z = (zr > 32767) ? 15'd32767 : zr[14:0];
		r.st = ST_OK;
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		if (idx != REG_UNUSED)
			geo[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(int x1, int y1, int x2, int y2, int o1, int o2, int o3);
		write_reg(REG_DET2_X, 16'(x1));
		write_reg(REG_DET2_Y, 16'(y1));
		write_reg(REG_DET3_X, 16'(x2));
		write_reg(REG_DET3_Y, 16'(y2));
		write_reg(REG_OFF1, 16'(o1));
		write_reg(REG_OFF2, 16'(o2));
		write_reg(REG_OFF3, 16'(o3));
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic send_times(logic signed [15:0] a1, logic signed [15:0] a2,
			logic signed [15:0] a3);
		int gap;
		in_valid <= 1'b1;
		time_det1 <= a1;
		time_det2 <= a2;
		time_det3 <= a3;
		do @(posedge clk); while (!in_ready);
		pending_dirs.push_back(solve_direction(a1, a2, a3));
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			gap = $urandom_range(4, 1);
			repeat (gap) @(negedge clk);
		end
	endtask

	// called at a falling edge
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_dirs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// delays that mostly keep the direction in view, sometimes full noise
	task automatic send_shower();
		int                 reach;
		int                 m;
		logic signed [15:0] a1;
		logic signed [15:0] d1;
		logic signed [15:0] d2;
		reach = (geo[REG_DET2_X] < 0 ? -geo[REG_DET2_X] : geo[REG_DET2_X])
			+ (geo[REG_DET2_Y] < 0 ? -geo[REG_DET2_Y] : geo[REG_DET2_Y]);
		m = (geo[REG_DET3_X] < 0 ? -geo[REG_DET3_X] : geo[REG_DET3_X])
			+ (geo[REG_DET3_Y] < 0 ? -geo[REG_DET3_Y] : geo[REG_DET3_Y]);
		if (m < reach)
			reach = m;
		reach = reach / 8 + 1;
		if ($urandom_range(99) < 25) begin
			send_times(16'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			a1 = 16'($urandom);
			d1 = 16'(int'($urandom_range(2 * reach)) - reach);
			d2 = 16'(int'($urandom_range(2 * reach)) - reach);
			send_times(a1, a1 + geo[REG_OFF1] + d1 - geo[REG_OFF2],
				a1 + geo[REG_OFF1] + d2 - geo[REG_OFF3]);
		end
	endtask

	task automatic test_degenerate();
		send_times(16'sh7FFF, 16'sh8000, 16'sh0000);
		send_times(16'sh8000, 16'sh7FFF, 16'shFFFF);
		wait_idle();
		set_geometry(1000, 2000, 2000, 4000, 0, 0, 0);
		wait_idle();
		send_times(16'sd5, -16'sd5, 16'sd100);
		wait_idle();
	endtask

	task automatic test_directed();
		set_geometry(1000, 0, 0, 1000, 0, 0, 0);
		@(negedge clk);
		send_times(16'sd0, 16'sd0, 16'sd0);
		send_times(16'sd0, -16'sd133, 16'sd0);
		send_times(16'sd0, 16'sd133, 16'sd0);
		send_times(16'sd0, -16'sd134, 16'sd0);
		send_times(16'sd0, 16'sd0, -16'sd133);
		send_times(16'sd0, 16'sd94, 16'sd94);
		send_times(16'sd0, 16'sd95, 16'sd95);
		send_times(16'sh7FFF, 16'sh8000, 16'sh7FFF);
		send_times(16'sh8000, 16'sh7FFF, 16'sh8000);
		send_times(16'shFFFF, 16'shFFFF, 16'sh0000);
		wait_idle();
		set_geometry(-32768, 32767, 32767, -32767, 32767, -32768, 16'sh5555);
		write_reg(REG_UNUSED, 16'h1234);
		@(negedge clk);
		send_times(16'sd0, 16'sd0, 16'sd0);
		send_times(16'sh8000, 16'sh7FFF, 16'sh8000);
		send_times(16'sh7FFF, 16'sh8000, 16'sh2AAA);
		send_times(-16'sd32767, 16'sd32767, -16'sd21846);
		wait_idle();
	endtask

	task automatic test_random(int x1, int y1, int x2, int y2, int o1, int o2, int o3,
			int count);
		set_geometry(x1, y1, x2, y2, o1, o2, o3);
		@(negedge clk);
		repeat (count) send_shower();
		wait_idle();
	endtask

	initial begin
		foreach (geo[i]) geo[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_degenerate();
		test_directed();
		test_random(5000, 100, -300, 6000, 0, 0, 0, 140);
		no_idle = 1'b1;
		test_random(-32768, 0, 0, -32768, 32767, -32768, 32767, 140);
		no_idle = 1'b0;
		test_random(20000, -8000, 12000, 25000, -32768, 32767, -32768, 140);
		test_random(150, 40, -90, 200, $urandom, $urandom, $urandom, 140);
		test_random($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, 140);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	always @(negedge clk)
		out_ready <= no_idle || $urandom_range(99) >= 29;

	always @(posedge clk) begin
		direction_t want;
		if (out_valid && out_ready) begin
			if (pending_dirs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d z=%0d st=%0d",
						dir_x, dir_y, dir_z, status);
			end else begin
				want = pending_dirs.pop_front();
				if (dir_x !== want.x || dir_y !== want.y || dir_z !== want.z
						|| status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp x=%0d y=%0d z=%0d st=%0d got x=%0d y=%0d z=%0d st=%0d",
							want.x, want.y, want.z, want.st, dir_x, dir_y, dir_z, status);
				end
			end
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end
endmodule
